FILE: rtl/core/crnc_pkg.sv
`timescale 1ns / 1ps
package crnc_pkg;

  localparam int unsigned CAT_COUNT_DEF = 8;

  // shared serial arithmetic unit
  localparam int unsigned ACC_W  = 51;
  localparam int unsigned DIG_W  = 25;
  localparam int unsigned STEP_W = 5;

  localparam int unsigned RATE_W  = 32;   // smoothed rate, Q16.16
  localparam int unsigned SHARE_W = 17;   // share / baseline, Q1.16
  localparam int unsigned IN_W    = 25;   // sample rate, Q16.8 signed

  localparam logic [STEP_W-1:0] MUL_STEPS   = STEP_W'(17);
  localparam logic [STEP_W-1:0] QDIV_STEPS  = STEP_W'(17);
  localparam logic [STEP_W-1:0] RATIO_STEPS = STEP_W'(25);

  localparam int unsigned NEAR_ZERO = 7;
  localparam logic [15:0] SHARE_RST = 16'h2000;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_ALPHA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ALPHA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_THR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_THR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARES_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARES_HIGH = 3'd5;

  // intensity codes
  localparam logic [1:0] INT_MILD    = 2'd0;
  localparam logic [1:0] INT_CONSID  = 2'd1;
  localparam logic [1:0] INT_EXTREME = 2'd2;

  typedef enum logic {
    ARITH_MUL,
    ARITH_DIV
  } arith_op_e;

  // MUL: acc = init + opa * opb (opb unsigned, LSB first)
  // DIV: rem = init, opb supplies dividend bits MSB first, opa is divisor
  typedef struct packed {
    arith_op_e                op;
    logic signed [ACC_W-1:0]  init;
    logic signed [ACC_W-1:0]  opa;
    logic [DIG_W-1:0]         opb;
    logic [STEP_W-1:0]        steps;
  } arith_cmd_t;

endpackage

FILE: rtl/core/category_rate_novelty_classifier.sv
`timescale 1ns / 1ps
// Rate samples and evaluate beats are worked on one at a time, set by the shared
// bit-serial multiply/divide unit (one bit per cycle); the next beat is taken
// while a result waits.
// Reset (async, active low): rates zero and unseen, baselines from the share
// register defaults, no dominant category, registers at their defaults.
module category_rate_novelty_classifier #(
  parameter int unsigned CATEGORY_COUNT = crnc_pkg::CAT_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // category[3:0], sample_rate[28:4]
  input  logic                             s_axis_tuser,  // operation
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // dominant[3:0], intensity[5:4],
                                                          // rejected[6], skipped[7]
  input  logic                             cfg_we_i,
  input  logic [crnc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [63:0]                      cfg_data_i
);
  import crnc_pkg::*;

  localparam int unsigned IDX_W = (CATEGORY_COUNT > 1) ? $clog2(CATEGORY_COUNT) : 1;
  localparam int unsigned DOM_W = $clog2(CATEGORY_COUNT + 1);
  localparam int unsigned TOT_W = RATE_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CATEGORY_COUNT - 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SAMPLE, ST_BLEND_W, ST_SUM, ST_SUM_CHK, ST_SHARE, ST_SHARE_W,
    ST_PICK, ST_P1_W, ST_P2_W, ST_BASE, ST_BASE_W, ST_BASE_CHK, ST_NORM, ST_NORM_W,
    ST_GRADE, ST_GRADE2, ST_GRADE_W, ST_OUT
  } state_e;

  state_e state_q;

  // registers
  logic [15:0] rate_alpha_q, base_alpha_q, mod_thr_q, ext_thr_q;

  // per-category state
  logic [RATE_W-1:0]  smooth_q [CATEGORY_COUNT];
  logic               seen_q   [CATEGORY_COUNT];
  logic [SHARE_W-1:0] base_q   [CATEGORY_COUNT];
  logic [SHARE_W-1:0] share_q  [CATEGORY_COUNT];
  logic [DOM_W-1:0]   dom_q;

  // working state
  logic [IDX_W-1:0]        idx_q;
  logic [IN_W-1:0]         rate_q;
  logic                    rej_q, skip_q;
  logic [1:0]              int_q;
  logic [TOT_W-1:0]        total_q;
  logic signed [17:0]      best_d_q;
  logic [SHARE_W-1:0]      best_b_q;
  logic signed [ACC_W-1:0] p1_q;
  logic                    m_valid_q;
  logic [7:0]              m_data_q;

  // arithmetic unit
  arith_cmd_t              cmd_q;
  logic                    start_q;
  logic                    ar_busy;
  logic signed [ACC_W-1:0] ar_acc;
  logic [DIG_W-1:0]        ar_quo;
  logic                    ar_done;

  crnc_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .cmd_i  (cmd_q),
    .busy_o (ar_busy),
    .acc_o  (ar_acc),
    .quo_o  (ar_quo)
  );

  assign ar_done = !ar_busy && !start_q;

  // one read port on every array, all at idx_q
  logic [RATE_W-1:0]  sm_rd;
  logic               seen_rd;
  logic [SHARE_W-1:0] base_rd, share_rd;
  logic signed [17:0] d_val;
  logic [RATE_W-1:0]  fresh;
  logic [TOT_W:0]     norm_num;
  logic [15:0]        ratio;
  logic               last;
  logic               accept;

  assign sm_rd    = smooth_q[idx_q];
  assign seen_rd  = seen_q[idx_q];
  assign base_rd  = base_q[idx_q];
  assign share_rd = share_q[idx_q];
  assign d_val    = $signed({1'b0, share_rd}) - $signed({1'b0, base_rd});
  assign fresh    = {rate_q[IN_W-2:0], 8'h00};
  assign norm_num = (TOT_W + 1)'({base_rd, 16'h0000}) + (TOT_W + 1)'(total_q >> 1);
  assign ratio    = (|ar_quo[DIG_W-1:16]) ? 16'hFFFF : ar_quo[15:0];
  assign last     = (idx_q == LAST_IDX);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // share has no reset value; written by evaluation only
  logic               share_we;
  logic [SHARE_W-1:0] share_wd;

  always_comb begin
    share_we = 1'b0;
    share_wd = ar_quo[SHARE_W-1:0];
    if (state_q == ST_SHARE && !seen_rd) begin
      share_we = 1'b1;
      share_wd = '0;
    end else if (state_q == ST_SHARE_W && ar_done) begin
      share_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (share_we) share_q[idx_q] <= share_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rate_alpha_q <= 16'd6554;
      base_alpha_q <= 16'd655;
      mod_thr_q    <= 16'd307;
      ext_thr_q    <= 16'd512;
      for (int i = 0; i < CATEGORY_COUNT; i++) begin
        smooth_q[i] <= '0;
        seen_q[i]   <= 1'b0;
        base_q[i]   <= (i < 8) ? SHARE_W'(SHARE_RST) : '0;
      end
      dom_q     <= DOM_W'(CATEGORY_COUNT);
      idx_q     <= '0;
      rate_q    <= '0;
      rej_q     <= 1'b0;
      skip_q    <= 1'b0;
      int_q     <= INT_MILD;
      total_q   <= '0;
      best_d_q  <= '0;
      best_b_q  <= '0;
      p1_q      <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      cmd_q     <= '0;
      start_q   <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (m_axis_tready) m_valid_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_RATE_ALPHA: rate_alpha_q <= cfg_data_i[15:0];
          CFG_BASE_ALPHA: base_alpha_q <= cfg_data_i[15:0];
          CFG_MOD_THR:    mod_thr_q    <= cfg_data_i[15:0];
          CFG_EXT_THR:    ext_thr_q    <= cfg_data_i[15:0];
          CFG_SHARES_LOW: begin
            for (int k = 0; k < 4; k++)
              if (k < CATEGORY_COUNT) base_q[k] <= SHARE_W'(cfg_data_i[16*k +: 16]);
          end
          CFG_SHARES_HIGH: begin
            for (int k = 0; k < 4; k++)
              if (k + 4 < CATEGORY_COUNT)
                base_q[k+4] <= SHARE_W'(cfg_data_i[16*k +: 16]);
          end
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            rate_q <= s_axis_tdata[28:4];
            rej_q  <= 1'b0;
            skip_q <= 1'b0;
            if (!s_axis_tuser) begin
              if (5'(s_axis_tdata[3:0]) >= 5'(CATEGORY_COUNT) || s_axis_tdata[28]) begin
                rej_q   <= 1'b1;
                state_q <= ST_GRADE;
              end else begin
                idx_q   <= s_axis_tdata[IDX_W-1:0];
                state_q <= ST_SAMPLE;
              end
            end else begin
              idx_q   <= '0;
              total_q <= '0;
              state_q <= ST_SUM;
            end
          end
        end

        // rate sample: first one loads, later ones blend
        ST_SAMPLE: begin
          if (!seen_rd) begin
            smooth_q[idx_q] <= fresh;
            seen_q[idx_q]   <= 1'b1;
            state_q         <= ST_GRADE;
          end else begin
            cmd_q.op    <= ARITH_MUL;
            cmd_q.init  <= ACC_W'({sm_rd, 16'h8000});
            cmd_q.opa   <= ACC_W'($signed({1'b0, fresh}) - $signed({1'b0, sm_rd}));
            cmd_q.opb   <= DIG_W'(rate_alpha_q);
            cmd_q.steps <= MUL_STEPS;
            start_q     <= 1'b1;
            state_q     <= ST_BLEND_W;
          end
        end
        ST_BLEND_W: begin
          if (ar_done) begin
            smooth_q[idx_q] <= ar_acc[RATE_W+15:16];
            state_q         <= ST_GRADE;
          end
        end

        // total of smoothed rates, unseen ones count as zero
        ST_SUM: begin
          if (seen_rd) total_q <= total_q + TOT_W'(sm_rd);
          if (last) state_q <= ST_SUM_CHK;
          else idx_q <= idx_q + IDX_W'(1);
        end
        ST_SUM_CHK: begin
          idx_q <= '0;
          if (total_q < TOT_W'(NEAR_ZERO)) begin
            skip_q  <= 1'b1;
            state_q <= ST_GRADE;
          end else begin
            state_q <= ST_SHARE;
          end
        end

        // share = floor(rate * 2^16 / total)
        ST_SHARE: begin
          if (!seen_rd) begin
            if (last) begin
              idx_q    <= '0;
              best_d_q <= -18'sd1;
              best_b_q <= SHARE_W'(1);
              state_q  <= ST_PICK;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end else begin
            cmd_q.op    <= ARITH_DIV;
            cmd_q.init  <= ACC_W'(sm_rd >> 1);
            cmd_q.opa   <= ACC_W'(total_q);
            cmd_q.opb   <= {sm_rd[0], 24'h000000};
            cmd_q.steps <= QDIV_STEPS;
            start_q     <= 1'b1;
            state_q     <= ST_SHARE_W;
          end
        end
        ST_SHARE_W: begin
          if (ar_done) begin
            if (last) begin
              idx_q    <= '0;
              best_d_q <= -18'sd1;
              best_b_q <= SHARE_W'(1);
              state_q  <= ST_PICK;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= ST_SHARE;
            end
          end
        end

        // dominant: largest (share - base) / base by cross products
        ST_PICK: begin
          if (base_rd < SHARE_W'(NEAR_ZERO)) begin
            if (last) begin
              idx_q   <= '0;
              total_q <= '0;
              state_q <= ST_BASE;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end else begin
            cmd_q.op    <= ARITH_MUL;
            cmd_q.init  <= '0;
            cmd_q.opa   <= ACC_W'(d_val);
            cmd_q.opb   <= DIG_W'(best_b_q);
            cmd_q.steps <= MUL_STEPS;
            start_q     <= 1'b1;
            state_q     <= ST_P1_W;
          end
        end
        ST_P1_W: begin
          if (ar_done) begin
            p1_q        <= ar_acc;
            cmd_q.op    <= ARITH_MUL;
            cmd_q.init  <= '0;
            cmd_q.opa   <= ACC_W'(best_d_q);
            cmd_q.opb   <= DIG_W'(base_rd);
            cmd_q.steps <= MUL_STEPS;
            start_q     <= 1'b1;
            state_q     <= ST_P2_W;
          end
        end
        ST_P2_W: begin
          if (ar_done) begin
            if (p1_q > ar_acc) begin
              best_d_q <= d_val;
              best_b_q <= base_rd;
              dom_q    <= DOM_W'(idx_q);
            end
            if (last) begin
              idx_q   <= '0;
              total_q <= '0;
              state_q <= ST_BASE;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= ST_PICK;
            end
          end
        end

        // baseline update: zero baseline takes the share, else blend
        ST_BASE: begin
          if (base_rd == '0) begin
            base_q[idx_q] <= share_rd;
            total_q       <= total_q + TOT_W'(share_rd);
            if (last) state_q <= ST_BASE_CHK;
            else idx_q <= idx_q + IDX_W'(1);
          end else begin
            cmd_q.op    <= ARITH_MUL;
            cmd_q.init  <= ACC_W'({base_rd, 16'h8000});
            cmd_q.opa   <= ACC_W'(d_val);
            cmd_q.opb   <= DIG_W'(base_alpha_q);
            cmd_q.steps <= MUL_STEPS;
            start_q     <= 1'b1;
            state_q     <= ST_BASE_W;
          end
        end
        ST_BASE_W: begin
          if (ar_done) begin
            base_q[idx_q] <= ar_acc[SHARE_W+15:16];
            total_q       <= total_q + TOT_W'(ar_acc[SHARE_W+15:16]);
            if (last) begin
              state_q <= ST_BASE_CHK;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= ST_BASE;
            end
          end
        end
        ST_BASE_CHK: begin
          idx_q <= '0;
          if (total_q < TOT_W'(NEAR_ZERO)) state_q <= ST_GRADE;
          else state_q <= ST_NORM;
        end

        // renormalize, rounding half up
        ST_NORM: begin
          cmd_q.op    <= ARITH_DIV;
          cmd_q.init  <= ACC_W'(norm_num >> 17);
          cmd_q.opa   <= ACC_W'(total_q);
          cmd_q.opb   <= {norm_num[16:0], 8'h00};
          cmd_q.steps <= QDIV_STEPS;
          start_q     <= 1'b1;
          state_q     <= ST_NORM_W;
        end
        ST_NORM_W: begin
          if (ar_done) begin
            base_q[idx_q] <= ar_quo[SHARE_W-1:0];
            if (last) begin
              state_q <= ST_GRADE;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= ST_NORM;
            end
          end
        end

        // intensity from share / baseline of the dominant category
        ST_GRADE: begin
          if (dom_q >= DOM_W'(CATEGORY_COUNT)) begin
            int_q   <= INT_MILD;
            state_q <= ST_OUT;
          end else begin
            idx_q   <= dom_q[IDX_W-1:0];
            state_q <= ST_GRADE2;
          end
        end
        ST_GRADE2: begin
          if (base_rd < SHARE_W'(NEAR_ZERO)) begin
            int_q   <= INT_EXTREME;
            state_q <= ST_OUT;
          end else begin
            cmd_q.op    <= ARITH_DIV;
            cmd_q.init  <= '0;
            cmd_q.opa   <= ACC_W'(base_rd);
            cmd_q.opb   <= {share_rd, 8'h00};
            cmd_q.steps <= RATIO_STEPS;
            start_q     <= 1'b1;
            state_q     <= ST_GRADE_W;
          end
        end
        ST_GRADE_W: begin
          if (ar_done) begin
            if (ratio > ext_thr_q) int_q <= INT_EXTREME;
            else if (ratio > mod_thr_q) int_q <= INT_CONSID;
            else int_q <= INT_MILD;
            state_q <= ST_OUT;
          end
        end

        // result register; input side reopens once it is loaded
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {skip_q, rej_q, int_q, 4'(dom_q)};
            state_q   <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/crnc_arith.sv
`timescale 1ns / 1ps
module crnc_arith (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  crnc_pkg::arith_cmd_t                cmd_i,
  output logic                                busy_o,
  output logic signed [crnc_pkg::ACC_W-1:0]   acc_o,
  output logic [crnc_pkg::DIG_W-1:0]          quo_o
);
  import crnc_pkg::*;

  logic [STEP_W-1:0]       cnt_q;
  arith_op_e               op_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] opa_q;
  logic [DIG_W-1:0]        opb_q;
  logic [DIG_W-1:0]        quo_q;
  logic signed [ACC_W-1:0] rem_sh;
  logic signed [ACC_W-1:0] rem_sub;

  assign rem_sh  = {acc_q[ACC_W-2:0], opb_q[DIG_W-1]};
  assign rem_sub = rem_sh - opa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      op_q  <= ARITH_MUL;
    end else if (start_i) begin
      cnt_q <= cmd_i.steps;
      op_q  <= cmd_i.op;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= cmd_i.init;
      opa_q <= cmd_i.opa;
      opb_q <= cmd_i.opb;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      if (op_q == ARITH_MUL) begin
        if (opb_q[0]) acc_q <= acc_q + opa_q;
        opa_q <= opa_q <<< 1;
        opb_q <= opb_q >> 1;
      end else begin
        if (!rem_sub[ACC_W-1]) begin
          acc_q <= rem_sub;
          quo_q <= {quo_q[DIG_W-2:0], 1'b1};
        end else begin
          acc_q <= rem_sh;
          quo_q <= {quo_q[DIG_W-2:0], 1'b0};
        end
        opb_q <= opb_q << 1;
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign acc_o  = acc_q;
  assign quo_o  = quo_q;

endmodule
